// ===== hdl/generational_handle_table_top_defines.svh =====
// Assertion macros shared by the checker of the handle table.
// Depends on nothing; take it in by include with the bare file name.
`ifndef GENERATIONAL_HANDLE_TABLE_TOP_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_TOP_DEFINES_SVH

// Clocked assertion, masked while reset is held.
`define GHT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("handle table assertion failed");

// Clocked assertion that also holds during reset.
`define GHT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("handle table assertion failed during reset");

`endif

// ===== hdl/ght_pkg.sv =====
// Shared types and constants of the generational handle table.
// Depends on nothing; ght_match, the top level and the checker import it.
package ght_pkg;

  localparam int SLOTS_DEF = 1024;
  localparam int CFG_W     = 11;
  localparam int HANDLE_W  = 35;
  localparam int FREED_W   = 11;
  localparam logic [CFG_W-1:0] SLOT_COUNT_RST = 11'd1024;
  localparam logic [15:0] GEN_MAX = 16'hFFFF;
  localparam logic [15:0] GEN_ONE = 16'd1;

  typedef enum logic [2:0] {
    CMD_INIT    = 3'd0,
    CMD_REG     = 3'd1,
    CMD_RESOLVE = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_RELOWN  = 3'd4,
    CMD_QUERY   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_KIND = 2'd2,
    STS_DEAD = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [HANDLE_W-1:0] handle;
    logic [2:0]          kind;
    logic [31:0]         payload;
    logic [31:0]         owner;
  } in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] out_handle;
    logic [31:0]         out_payload;
    logic [2:0]          out_kind;
    logic [31:0]         out_owner;
    logic [FREED_W-1:0]  freed_count;
  } out_t;

  typedef struct packed {
    logic live;
    logic kind_ok;
  } match_t;

endpackage

// ===== hdl/ght_ram.sv =====
// Single-port slot memory with registered read data.
// Depends on nothing; sized by its parameters.
module ght_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int WIDTH = 95
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/ght_match.sv =====
// Liveness compare of one handle against one slot word.
// Depends on ght_pkg.
module ght_match (
  input  logic [ght_pkg::HANDLE_W-1:0] handle,
  input  logic [2:0]                   req_kind,
  input  logic                         slot_live,
  input  logic [2:0]                   slot_kind,
  input  logic [15:0]                  slot_gen,
  output ght_pkg::match_t              result
);
  import ght_pkg::*;

  always_comb begin
    result.live    = slot_live && (slot_kind == handle[34:32]) && (slot_gen == handle[31:16]);
    result.kind_ok = (slot_kind == req_kind);
  end
endmodule

// ===== hdl/generational_handle_table_top.sv =====
// Top level of the generational handle table: sequencer, slot memory, compare.
// Depends on ght_pkg, ght_ram and ght_match.
//
// Use: one command beat enters on in_valid/in_ready (in_data), one result beat
// leaves on out_valid/out_ready (out_data) for every command. cfg_valid/cfg_ready
// write slot_count, taken up by the next init command.
// Steps, from the accepting edge to the result showing on out_valid:
//  - register, resolve, release, query: the slot memory is read as the command
//    is taken and the op state writes the slot word where needed; the command
//    is settled in idle without a read (null payload, full table, out-of-range handle).
//  - release_owned: one memory read and one check or write for every active
//    slot, owned or not; settled in idle when skipped.
//  - init: every slot word rewritten, one per cycle.
// The single memory port sets these steps. One command at a time:
// in_ready is high only in idle with the result register empty.
// Reset: a clear pass rebuilds the free list for min(SLOTS, 1024) slots with
// slot_count 1024; commands are held off meanwhile, configuration writes are accepted.
// Stall: a result waits in the output register while out_ready is low, and no
// new command is taken until it leaves.
module generational_handle_table_top #(
  parameter int SLOTS = ght_pkg::SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ght_pkg::in_t         in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ght_pkg::out_t        out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ght_pkg::CFG_W-1:0] cfg_data
);
  import ght_pkg::*;

  localparam int IW = $clog2(SLOTS + 1);
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WW = 84 + IW;
  localparam int RST_ACT = (SLOTS < 1024) ? SLOTS : 1024;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_OP    = 5'b00100,
    S_SRD   = 5'b01000,
    S_SEV   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt, act_r, act_nxt, head_r, head_nxt;
  logic [IW-1:0] owned_r, owned_nxt, idx_r, idx_nxt;
  logic [FREED_W-1:0] freed_r, freed_nxt;
  logic emit_r, emit_nxt, out_valid_r, out_valid_nxt;
  logic [CFG_W-1:0] slot_count_r;
  in_t in_r, in_nxt;
  out_t out_r, out_nxt;

  logic          we;
  logic [AW-1:0] addr;
  logic [WW-1:0] wdata, rdata;

  logic          r_live;
  logic [2:0]    r_kind;
  logic [15:0]   r_gen;
  logic [IW-1:0] r_next;
  logic [31:0]   r_owner;
  match_t        m;

  logic [IW:0]   c1;
  logic [15:0]   gen_new;
  logic [31:0]   sc;
  logic [IW-1:0] act_sat;
  logic [15:0]   hidx;
  logic          in_rng;

  assign {r_live, r_kind, r_gen, r_next, r_owner} = rdata[WW-1:32];

  ght_ram #(.DEPTH(SLOTS), .AW(AW), .WIDTH(WW)) u_ram (
    .clk, .we, .addr, .wdata, .rdata
  );

  ght_match u_match (
    .handle(in_r.handle), .req_kind(in_r.kind), .slot_live(r_live),
    .slot_kind(r_kind), .slot_gen(r_gen), .result(m)
  );

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // Saturate slot_count into 1..SLOTS for the next init.
  assign sc      = 32'(slot_count_r);
  assign act_sat = (sc == 32'd0) ? IW'(1) : ((sc > 32'(SLOTS)) ? IW'(SLOTS) : IW'(sc));
  assign hidx    = in_data.handle[15:0];
  assign in_rng  = (in_data.handle[34:32] != 3'd0) && (hidx != 16'd0) &&
                   (32'(hidx) <= 32'(act_r));
  assign c1      = {1'b0, cnt_r} + (IW+1)'(1);
  assign gen_new = (r_gen == GEN_MAX) ? GEN_ONE : r_gen + 16'd1;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    act_nxt       = act_r;
    head_nxt      = head_r;
    owned_nxt     = owned_r;
    idx_nxt       = idx_r;
    freed_nxt     = freed_r;
    emit_nxt      = emit_r;
    in_nxt        = in_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    we            = 1'b0;
    addr          = AW'(idx_r - IW'(1));
    wdata         = '0;

    case (state_r)
      S_CLEAR: begin
        // Rewrite one slot per cycle: generation one, chained free link.
        we    = 1'b1;
        addr  = cnt_r[AW-1:0];
        wdata = {1'b0, 3'd0, GEN_ONE,
                 (c1 < {1'b0, act_r}) ? IW'(c1 + (IW+1)'(1)) : IW'(0), 64'd0};
        if (cnt_r == IW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
          if (emit_r) begin
            out_nxt       = '0;
            out_valid_nxt = 1'b1;
          end
        end else begin
          cnt_nxt = IW'(c1);
        end
      end

      S_IDLE: begin
        if (in_valid && in_ready) begin
          in_nxt  = in_data;
          out_nxt = '0;
          case (cmd_t'(in_data.cmd))
            CMD_INIT: begin
              act_nxt   = act_sat;
              cnt_nxt   = '0;
              head_nxt  = IW'(1);
              owned_nxt = '0;
              emit_nxt  = 1'b1;
              state_nxt = S_CLEAR;
            end
            CMD_REG: begin
              if (in_data.payload == 32'd0) begin
                out_valid_nxt = 1'b1;
              end else if (head_r == '0 || head_r > act_r) begin
                out_nxt.status = STS_FULL;
                out_valid_nxt  = 1'b1;
              end else begin
                idx_nxt   = head_r;
                addr      = AW'(head_r - IW'(1));
                state_nxt = S_OP;
              end
            end
            CMD_RESOLVE, CMD_RELEASE, CMD_QUERY: begin
              if (!in_rng) begin
                out_nxt.status = STS_DEAD;
                out_valid_nxt  = 1'b1;
              end else begin
                idx_nxt   = IW'(hidx);
                addr      = AW'(hidx - 16'd1);
                state_nxt = S_OP;
              end
            end
            CMD_RELOWN: begin
              if (owned_r == '0 || in_data.owner == 32'd0) begin
                out_valid_nxt = 1'b1;
              end else begin
                cnt_nxt   = '0;
                freed_nxt = '0;
                state_nxt = S_SRD;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_OP: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        case (cmd_t'(in_r.cmd))
          CMD_REG: begin
            we       = 1'b1;
            wdata    = {1'b1, in_r.kind, r_gen, IW'(0), in_r.owner, in_r.payload};
            head_nxt = r_next;
            if (in_r.owner != 32'd0) begin
              owned_nxt = owned_r + IW'(1);
            end
            out_nxt.out_handle = {in_r.kind, r_gen, 16'(idx_r)};
          end
          CMD_RESOLVE: begin
            if (!m.live) begin
              out_nxt.status = STS_DEAD;
            end else if (!m.kind_ok) begin
              out_nxt.status = STS_KIND;
            end else begin
              out_nxt.out_payload = rdata[31:0];
            end
          end
          CMD_RELEASE: begin
            if (!m.live) begin
              out_nxt.status = STS_DEAD;
            end else begin
              we       = 1'b1;
              wdata    = {1'b0, 3'd0, gen_new, head_r, 64'd0};
              head_nxt = idx_r;
              if (r_owner != 32'd0 && owned_r != '0) begin
                owned_nxt = owned_r - IW'(1);
              end
              out_nxt.freed_count = FREED_W'(1);
            end
          end
          CMD_QUERY: begin
            if (!m.live) begin
              out_nxt.status = STS_DEAD;
            end else begin
              out_nxt.out_kind  = r_kind;
              out_nxt.out_owner = r_owner;
            end
          end
          default: begin
            out_nxt = '0;
          end
        endcase
      end

      S_SRD: begin
        addr      = cnt_r[AW-1:0];
        state_nxt = S_SEV;
      end

      S_SEV: begin
        // Free the slot when it is live and belongs to the owner.
        addr = cnt_r[AW-1:0];
        if (r_live && r_owner == in_r.owner) begin
          we        = 1'b1;
          wdata     = {1'b0, 3'd0, gen_new, head_r, 64'd0};
          head_nxt  = IW'(c1);
          freed_nxt = freed_r + FREED_W'(1);
          if (owned_r != '0) begin
            owned_nxt = owned_r - IW'(1);
          end
        end
        if (c1 == {1'b0, act_r}) begin
          out_nxt.freed_count = freed_nxt;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end else begin
          cnt_nxt   = IW'(c1);
          state_nxt = S_SRD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cnt_r        <= '0;
      act_r        <= IW'(RST_ACT);
      head_r       <= IW'(1);
      owned_r      <= '0;
      emit_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      slot_count_r <= SLOT_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      act_r       <= act_nxt;
      head_r      <= head_nxt;
      owned_r     <= owned_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        slot_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    in_r    <= in_nxt;
    out_r   <= out_nxt;
    idx_r   <= idx_nxt;
    freed_r <= freed_nxt;
  end
endmodule

// ===== hdl/ght_checker.sv =====
// Port-level checker of the handle table, bound to the top level.
// Depends on ght_pkg and generational_handle_table_top_defines.svh.
`include "generational_handle_table_top_defines.svh"
module ght_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input ght_pkg::in_t         in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input ght_pkg::out_t        out_data,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [ght_pkg::CFG_W-1:0] cfg_data
);
  import ght_pkg::*;

  `GHT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `GHT_ASSERT(a_one_cmd, clk, rst_n, out_valid |-> !in_ready)
  `GHT_ASSERT(a_busy_after_beat, clk, rst_n, in_valid && in_ready |=> !in_ready)
  `GHT_ASSERT(a_fail_clean, clk, rst_n,
    out_valid && out_data.status != 2'd0 |-> out_data.freed_count == '0 && out_data.out_payload == 32'd0)
  `GHT_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !out_valid && !in_ready)
endmodule

bind generational_handle_table_top ght_checker u_ght_checker (.*);
